// ===== rtl/bta_pkg.sv =====
`timescale 1ns / 1ps
package bta_pkg;

    // tree geometry
    localparam int REGIONS        = 8;
    localparam int TREE_LEVELS    = 12;
    localparam int MIN_BLOCK_BITS = 12;
    localparam int REGION_BITS    = MIN_BLOCK_BITS + TREE_LEVELS - 1;

    // derived widths
    localparam int REG_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CNT_W   = $clog2(REGIONS + 1);
    localparam int NODE_W  = TREE_LEVELS;
    localparam int LV_W    = $clog2(TREE_LEVELS + 1);
    localparam int TOP_W   = $clog2(TREE_LEVELS + 1);
    localparam int STK_W   = $clog2(TREE_LEVELS);
    localparam int ADDR_W  = REG_W + NODE_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int OFF_W   = REGION_BITS + 1;

    localparam logic [NODE_W-1:0] FIRST_LEAF = NODE_W'((1 << (TREE_LEVELS - 1)) - 1);
    localparam logic [NODE_W-1:0] ROOT_NODE  = '0;

    // field widths
    localparam int BASE_W  = 32;
    localparam int COUNT_W = 4;
    localparam int REQ_W   = 24;
    localparam int FADDR_W = 32;

    // register indexes
    localparam logic CFG_MEMORY_BASE  = 1'b0;
    localparam logic CFG_REGION_COUNT = 1'b1;

    // item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_NOT_HELD = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] block_address;
        t_status     status;
    } t_result;

    // deepest tree level whose block still holds req bytes (root is level 1)
    function automatic logic [LV_W-1:0] want_level(input logic [REQ_W-1:0] req);
        logic [LV_W-1:0] want;
        want = LV_W'(1);
        for (int l = 1; l <= TREE_LEVELS; l++) begin
            if (64'(req) <= (64'(1) << (REGION_BITS + 1 - l))) begin
                want = LV_W'(l);
            end
        end
        return want;
    endfunction

endpackage

// ===== rtl/buddy_tree_page_allocator.sv =====
`timescale 1ns / 1ps
// allocate: a node read and evaluation per node visited, plus a child read and check per
//   split node, tried region by region, bound by the single read port of the node bit store
// free: a node read and evaluation per level climbed, a child check, a buddy read per merge step
// one transaction in flight; the result register lets the next request in while it waits
// reset: synchronous, active low; the node store is cleared one entry a cycle,
//   all 32768 entries at the built size, during which no request is taken
module buddy_tree_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // request_bytes[23:0], free_address[55:24]
    input  logic [0:0]  i_s_tuser,  // kind[0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // block_address[31:0], status[33:32], zero[39:34]
);

    logic [bta_pkg::BASE_W-1:0]  r_base;
    logic [bta_pkg::COUNT_W-1:0] r_count;
    logic                        r_out_valid;
    bta_pkg::t_result            r_out;
    bta_pkg::t_result            eng_res;
    logic                        eng_valid;
    logic                        eng_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'd16777216;
            r_count <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bta_pkg::CFG_MEMORY_BASE:  r_base  <= i_cfg_data;
                bta_pkg::CFG_REGION_COUNT: r_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    bta_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_kind      (i_s_tuser[0]),
        .i_req       (i_s_tdata[23:0]),
        .i_faddr     (i_s_tdata[55:24]),
        .i_base      (r_base),
        .i_count     (r_count),
        .o_res_valid (eng_valid),
        .i_res_ready (eng_ready),
        .o_res       (eng_res)
    );

    // output register
    assign eng_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ready) begin
            r_out_valid <= eng_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ready && eng_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.status, r_out.block_address};

endmodule

// ===== rtl/bta_ram.sv =====
`timescale 1ns / 1ps
module bta_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bta_engine.sv =====
`timescale 1ns / 1ps
module bta_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [bta_pkg::REQ_W-1:0]      i_req,
    input  logic [bta_pkg::FADDR_W-1:0]    i_faddr,
    input  logic [bta_pkg::BASE_W-1:0]     i_base,
    input  logic [bta_pkg::COUNT_W-1:0]    i_count,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output bta_pkg::t_result               o_res
);

    typedef enum logic [16:0] {
        S_CLR  = 17'b00000000000000001,
        S_IDLE = 17'b00000000000000010,
        S_ARD  = 17'b00000000000000100,
        S_AEV  = 17'b00000000000001000,
        S_ARL  = 17'b00000000000010000,
        S_ARR  = 17'b00000000000100000,
        S_ACH  = 17'b00000000001000000,
        S_AADR = 17'b00000000010000000,
        S_FRD  = 17'b00000000100000000,
        S_FEV  = 17'b00000001000000000,
        S_FRL  = 17'b00000010000000000,
        S_FRR  = 17'b00000100000000000,
        S_FCH  = 17'b00001000000000000,
        S_MRD  = 17'b00010000000000000,
        S_MEV  = 17'b00100000000000000,
        S_DONE = 17'b01000000000000000,
        S_SPARE = 17'b10000000000000000
    } t_state;

    t_state                          r_state, n_state;
    logic [bta_pkg::ADDR_W-1:0]      r_clr, n_clr;
    logic [bta_pkg::REG_W-1:0]       r_region, n_region;
    logic [bta_pkg::NODE_W-1:0]      r_node, n_node;
    logic [bta_pkg::LV_W-1:0]        r_lvl, n_lvl;
    logic [bta_pkg::LV_W-1:0]        r_want, n_want;
    logic [bta_pkg::TOP_W-1:0]       r_top, n_top;
    logic                            r_lc, n_lc;
    logic [bta_pkg::NODE_W-1:0]      r_stk_node [bta_pkg::TREE_LEVELS];
    logic [bta_pkg::LV_W-1:0]        r_stk_lvl  [bta_pkg::TREE_LEVELS];
    bta_pkg::t_result                r_res, n_res;

    logic                            push_en;
    logic [bta_pkg::NODE_W-1:0]      push_node;

    logic                            ram_we;
    logic                            ram_wdata;
    logic [bta_pkg::NODE_W-1:0]      wr_node;
    logic [bta_pkg::NODE_W-1:0]      rd_node;
    logic [bta_pkg::ADDR_W-1:0]      ram_waddr;
    logic [bta_pkg::ADDR_W-1:0]      ram_raddr;
    logic                            ram_rdata;

    logic [bta_pkg::CNT_W-1:0]       n_eff;
    logic [7:0]                      count8;
    logic [bta_pkg::NODE_W-1:0]      lc_node, rc_node, parent_node, buddy_node;
    logic [bta_pkg::TOP_W-1:0]       top_m1;
    logic                            last_region;
    logic [bta_pkg::FADDR_W-1:0]     f_off;
    logic [63:0]                     f_region;
    logic [bta_pkg::OFF_W-1:0]       off_ext;
    logic [7:0]                      blk_sh;
    logic [bta_pkg::REGION_BITS-1:0] blk_off;
    logic [63:0]                     addr_sum;
    logic                            in_fire;

    // regions in use, clipped to the built count
    assign count8 = {4'b0, i_count};
    assign n_eff  = bta_pkg::CNT_W'((count8 > 8'(bta_pkg::REGIONS))
                                     ? 8'(bta_pkg::REGIONS) : count8);

    // tree neighbours of the current node
    assign lc_node     = {r_node[bta_pkg::NODE_W-2:0], 1'b1};
    assign rc_node     = {r_node[bta_pkg::NODE_W-2:0] + 1'b1, 1'b0};
    assign parent_node = (r_node - 1'b1) >> 1;
    assign buddy_node  = r_node[0] ? (r_node + 1'b1) : (r_node - 1'b1);
    assign top_m1      = r_top - 1'b1;
    assign last_region = ((bta_pkg::CNT_W + 1)'(r_region) + 1'b1)
                         >= (bta_pkg::CNT_W + 1)'(n_eff);

    // free address mapping
    assign f_off    = i_faddr - i_base;
    assign f_region = {32'b0, f_off} >> bta_pkg::REGION_BITS;

    // block address from node and level
    assign off_ext  = (bta_pkg::OFF_W'(r_node) + 1'b1) << blk_sh;
    assign blk_sh   = 8'(bta_pkg::REGION_BITS + 1) - 8'(r_lvl);
    assign blk_off  = bta_pkg::REGION_BITS'(off_ext - (bta_pkg::OFF_W'(1)
                                                       << bta_pkg::REGION_BITS));
    assign addr_sum = 64'({r_region, blk_off}) + 64'(i_base);

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_region  = r_region;
        n_node    = r_node;
        n_lvl     = r_lvl;
        n_want    = r_want;
        n_top     = r_top;
        n_lc      = r_lc;
        n_res     = r_res;
        push_en   = 1'b0;
        push_node = r_node;
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        wr_node   = r_node;
        rd_node   = r_node;
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.block_address = '0;
                    if (i_kind == bta_pkg::KIND_ALLOC) begin
                        n_want   = bta_pkg::want_level(i_req);
                        n_region = '0;
                        n_node   = bta_pkg::ROOT_NODE;
                        n_lvl    = bta_pkg::LV_W'(1);
                        n_top    = '0;
                        if (i_req == '0 ||
                            64'(i_req) > (64'(1) << bta_pkg::REGION_BITS)) begin
                            n_res.status = bta_pkg::ST_BAD_SIZE;
                            n_state      = S_DONE;
                        end else if (n_eff == '0) begin
                            n_res.status = bta_pkg::ST_NO_ROOM;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_ARD;
                        end
                    end else begin
                        n_region = bta_pkg::REG_W'(f_region);
                        n_node   = bta_pkg::FIRST_LEAF + bta_pkg::NODE_W'(
                                   (f_off >> bta_pkg::MIN_BLOCK_BITS)
                                   & 32'(bta_pkg::FIRST_LEAF));
                        if (f_region >= 64'(n_eff)) begin
                            n_res.status = bta_pkg::ST_NOT_HELD;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_ARD: begin
                n_state = S_AEV;
            end
            S_AEV: begin
                if (!ram_rdata) begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    if (r_lvl >= r_want) begin
                        n_state = S_AADR;
                    end else begin
                        n_node  = lc_node;
                        n_lvl   = r_lvl + 1'b1;
                        n_state = S_ARD;
                    end
                end else if (r_lvl >= r_want) begin
                    // taken at the wanted level: backtrack
                    if (r_top == '0) begin
                        if (last_region) begin
                            n_res.status = bta_pkg::ST_NO_ROOM;
                            n_state      = S_DONE;
                        end else begin
                            n_region = r_region + 1'b1;
                            n_node   = bta_pkg::ROOT_NODE;
                            n_lvl    = bta_pkg::LV_W'(1);
                            n_state  = S_ARD;
                        end
                    end else begin
                        n_top   = top_m1;
                        n_node  = r_stk_node[top_m1[bta_pkg::STK_W-1:0]];
                        n_lvl   = r_stk_lvl[top_m1[bta_pkg::STK_W-1:0]];
                        n_state = S_ARD;
                    end
                end else begin
                    n_state = S_ARL;
                end
            end
            S_ARL: begin
                rd_node = lc_node;
                n_state = S_ARR;
            end
            S_ARR: begin
                rd_node = rc_node;
                n_lc    = ram_rdata;
                n_state = S_ACH;
            end
            S_ACH: begin
                if (!r_lc && !ram_rdata) begin
                    // whole block in use: backtrack
                    if (r_top == '0) begin
                        if (last_region) begin
                            n_res.status = bta_pkg::ST_NO_ROOM;
                            n_state      = S_DONE;
                        end else begin
                            n_region = r_region + 1'b1;
                            n_node   = bta_pkg::ROOT_NODE;
                            n_lvl    = bta_pkg::LV_W'(1);
                            n_state  = S_ARD;
                        end
                    end else begin
                        n_top   = top_m1;
                        n_node  = r_stk_node[top_m1[bta_pkg::STK_W-1:0]];
                        n_lvl   = r_stk_lvl[top_m1[bta_pkg::STK_W-1:0]];
                        n_state = S_ARD;
                    end
                end else begin
                    // split node: right child first when it is marked
                    push_en   = 1'b1;
                    n_top     = r_top + 1'b1;
                    n_lvl     = r_lvl + 1'b1;
                    n_state   = S_ARD;
                    if (ram_rdata) begin
                        push_node = lc_node;
                        n_node    = rc_node;
                    end else begin
                        push_node = rc_node;
                        n_node    = lc_node;
                    end
                end
            end
            S_AADR: begin
                n_res.block_address = addr_sum[31:0];
                n_res.status        = bta_pkg::ST_OK;
                n_state             = S_DONE;
            end
            S_FRD: begin
                n_state = S_FEV;
            end
            S_FEV: begin
                if (ram_rdata) begin
                    if (r_node < bta_pkg::FIRST_LEAF) begin
                        n_state = S_FRL;
                    end else begin
                        ram_we  = 1'b1;
                        n_state = S_MRD;
                    end
                end else if (r_node == bta_pkg::ROOT_NODE) begin
                    n_res.status = bta_pkg::ST_NOT_HELD;
                    n_state      = S_DONE;
                end else begin
                    n_node  = parent_node;
                    n_state = S_FRD;
                end
            end
            S_FRL: begin
                rd_node = lc_node;
                n_state = S_FRR;
            end
            S_FRR: begin
                rd_node = rc_node;
                n_lc    = ram_rdata;
                n_state = S_FCH;
            end
            S_FCH: begin
                if (r_lc || ram_rdata) begin
                    n_res.status = bta_pkg::ST_NOT_HELD;
                    n_state      = S_DONE;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                rd_node = buddy_node;
                if (r_node == bta_pkg::ROOT_NODE) begin
                    n_res.status = bta_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_MEV;
                end
            end
            S_MEV: begin
                if (ram_rdata) begin
                    n_res.status = bta_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    ram_we  = 1'b1;
                    wr_node = parent_node;
                    n_node  = parent_node;
                    n_state = S_MRD;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_waddr = (r_state == S_CLR) ? r_clr : {r_region, wr_node};
    assign ram_raddr = {r_region, rd_node};

    // node bit store
    bta_ram #(
        .WIDTH (1),
        .DEPTH (bta_pkg::RAM_DEPTH)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_region <= n_region;
        r_node   <= n_node;
        r_lvl    <= n_lvl;
        r_want   <= n_want;
        r_lc     <= n_lc;
        r_res    <= n_res;
        if (push_en) begin
            r_stk_node[r_top[bta_pkg::STK_W-1:0]] <= push_node;
            r_stk_lvl[r_top[bta_pkg::STK_W-1:0]]  <= r_lvl + 1'b1;
        end
    end

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("node store written outside a transaction");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |-> (r_top < bta_pkg::TOP_W'(bta_pkg::TREE_LEVELS)))
        else $error("search stack overflow");

    a_fire_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted transaction left no work");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AEV) |-> (r_lvl <= r_want))
        else $error("search went below the wanted level");

endmodule
